[rtl/tbrs_pkg.sv]
// Package for the two-bank ring buffer segmenter: constants, payload types, sequencer states.
package tbrs_pkg;

	localparam int CHIP_BYTES  = 131072;
	localparam int CHUNK_BYTES = 4095;
	localparam int ADDR_W      = 17;
	localparam int PTR_W       = 18;
	localparam int LEN_W       = 16;

	localparam logic [PTR_W-1:0] RING_MASK = PTR_W'(2 * CHIP_BYTES - 1);

	typedef enum logic [1:0] {
		KIND_PUT   = 2'd0,
		KIND_GET   = 2'd1,
		KIND_CLEAR = 2'd2,
		KIND_NOP   = 2'd3
	} kind_t;

	typedef enum logic [1:0] {
		ST_IDLE,
		ST_CALC,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic [1:0]       kind;
		logic [LEN_W-1:0] length;
	} request_t;

	typedef struct packed {
		logic              chip_select;
		logic [ADDR_W-1:0] chip_address;
		logic [LEN_W-1:0]  byte_count;
		logic [LEN_W-1:0]  buffer_offset;
		logic              is_write;
		logic              last;
		logic [PTR_W-1:0]  fill_level;
		logic [PTR_W-1:0]  free_space;
	} result_t;

endpackage

[rtl/two_bank_ring_buffer_segmenter_top.sv]
// Top level of the two-bank ring buffer segmenter: pointer state and descriptor sequencer.
//
//  channel   signals                       transfer when
//  request   start, busy, request          start && !busy at clk rise
//  result    result_valid, result          result_valid high (one cycle, no stall)
//
// A request is accepted, its fill level is computed in ST_CALC, then ST_EMIT gives
// one descriptor per cycle from a single segment adder/compare, N descriptors from
// 1 (get, clear, empty put) up to 18 (a 65535-byte put, 16 full chunks plus a tail,
// plus one chip-boundary split). The last descriptor leaves the output register
// while the next request can already be accepted.
// Reset clears both ring pointers and the sequencer; no clearing pass is needed.
// The receiver cannot stall; each result is shown for exactly one cycle.
module two_bank_ring_buffer_segmenter_top
	import tbrs_pkg::*;
(
	input  logic     clk,
	input  logic     arst_n,
	input  logic     start,
	output logic     busy,
	input  request_t request,
	output logic     result_valid,
	output result_t  result
);

	state_t state_q, state_d;

	logic [PTR_W-1:0] wp_q, rp_q;
	logic [PTR_W-1:0] ptr_q;        // working pointer of the segment being cut
	logic [LEN_W-1:0] chunk_rem_q;  // bytes left in the current chunk
	logic [LEN_W-1:0] total_rem_q;  // bytes of the request after the current chunk
	logic [LEN_W-1:0] off_q;        // caller offset of the next byte
	logic             wr_q;
	logic [PTR_W-1:0] fill_q;

	logic [PTR_W-1:0] room;
	logic [LEN_W-1:0] seg;
	logic [LEN_W-1:0] chunk_rem_nx;
	logic             seg_last;
	logic [LEN_W-1:0] first_chunk;
	logic [LEN_W-1:0] next_chunk;

	logic accept;
	assign accept = start && !busy;
	assign busy   = (state_q != ST_IDLE);

	// shared segment unit: bytes up to the end of the current chip
	assign room = PTR_W'(CHIP_BYTES) - {1'b0, ptr_q[ADDR_W-1:0]};
	assign seg  = ({2'b00, chunk_rem_q} <= room) ? chunk_rem_q : room[LEN_W-1:0];
	assign chunk_rem_nx = chunk_rem_q - seg;
	assign seg_last     = (chunk_rem_nx == '0) && (total_rem_q == '0);

	assign first_chunk = (request.length > LEN_W'(CHUNK_BYTES)) ? LEN_W'(CHUNK_BYTES)
	                                                            : request.length;
	assign next_chunk  = (total_rem_q > LEN_W'(CHUNK_BYTES)) ? LEN_W'(CHUNK_BYTES)
	                                                         : total_rem_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		case (state_q)
			ST_IDLE: begin
				if (accept) state_d = ST_CALC;
			end
			ST_CALC: state_d = ST_EMIT;
			ST_EMIT: begin
				if (seg_last) state_d = ST_IDLE;
			end
			default: state_d = ST_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q         <= '0;
			rp_q         <= '0;
			result_valid <= 1'b0;
		end else begin
			result_valid <= (state_q == ST_EMIT);
			if (accept) begin
				case (request.kind)
					KIND_PUT: wp_q <= (wp_q + PTR_W'(request.length)) & RING_MASK;
					KIND_GET: rp_q <= (rp_q + PTR_W'(request.length)) & RING_MASK;
					KIND_CLEAR: begin
						wp_q <= '0;
						rp_q <= '0;
					end
					default: ;
				endcase
			end
		end
	end

	// working registers and output payload
	always_ff @(posedge clk) begin
		if (accept) begin
			off_q <= '0;
			case (request.kind)
				KIND_PUT: begin
					ptr_q       <= wp_q;
					chunk_rem_q <= first_chunk;
					total_rem_q <= request.length - first_chunk;
					wr_q        <= 1'b1;
				end
				KIND_GET: begin
					ptr_q       <= rp_q;
					chunk_rem_q <= request.length;
					total_rem_q <= '0;
					wr_q        <= 1'b0;
				end
				default: begin
					ptr_q       <= '0;
					chunk_rem_q <= '0;
					total_rem_q <= '0;
					wr_q        <= 1'b0;
				end
			endcase
		end
		if (state_q == ST_CALC) begin
			fill_q <= (wp_q - rp_q) & RING_MASK;
		end
		if (state_q == ST_EMIT) begin
			result.chip_select   <= ptr_q[PTR_W-1];
			result.chip_address  <= ptr_q[ADDR_W-1:0];
			result.byte_count    <= seg;
			result.buffer_offset <= off_q;
			result.is_write      <= wr_q;
			result.last          <= seg_last;
			result.fill_level    <= fill_q;
			result.free_space    <= RING_MASK - fill_q;
			ptr_q <= (ptr_q + PTR_W'(seg)) & RING_MASK;
			off_q <= off_q + seg;
			if (chunk_rem_nx == '0) begin
				chunk_rem_q <= next_chunk;
				total_rem_q <= total_rem_q - next_chunk;
			end else begin
				chunk_rem_q <= chunk_rem_nx;
			end
		end
	end

	a_strobe_after_busy: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> $past(busy))
		else $error("result strobe without a request in progress");

	a_results_contiguous: assert property (@(posedge clk) disable iff (!arst_n)
		(result_valid && !result.last) |=> result_valid)
		else $error("gap inside a descriptor run");

	a_accept_goes_busy: assert property (@(posedge clk) disable iff (!arst_n)
		(start && !busy) |=> busy)
		else $error("accepted request did not start the sequencer");

	a_level_sum: assert property (@(posedge clk) disable iff (!arst_n)
		result_valid |-> ((result.fill_level + result.free_space) == RING_MASK))
		else $error("fill level and free space disagree");

endmodule
